[hw/rtl/clr_pkg.sv]
// Package for the clipped line rasterizer: widths, codes and payload types.
package clr_pkg;

   localparam int COORD_BITS = 13;
   localparam int CLIP_BITS = 12;
   localparam int STRIDE_BITS = 13;
   localparam int OFF_BITS = 24;
   localparam int COLOR_BITS = 24;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int DEC_BITS = COORD_BITS + 4;
   localparam int CMP_BITS = ((COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS) + 1;
   localparam int CSR_DATA_BITS = 24;
   localparam int CSR_INDEX_BITS = 3;

   localparam int IN_RAW_BITS = 4 * COORD_BITS;
   localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;
   localparam int OUT_RAW_BITS = 2 * COORD_BITS + 1 + OFF_BITS + COLOR_BITS;
   localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [DEC_BITS-1:0] dec_type;
   typedef logic signed [CMP_BITS-1:0] cmp_type;
   typedef logic [OFF_BITS-1:0] off_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   // Major axis and minor direction of the current line
   typedef enum logic [1:0] {
      OCT_X_UP   = 2'd0,
      OCT_Y_UP   = 2'd1,
      OCT_X_DOWN = 2'd2,
      OCT_Y_DOWN = 2'd3
   } octant_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CLIP_X_MIN = 3'd0,
      REG_CLIP_X_MAX = 3'd1,
      REG_CLIP_Y_MIN = 3'd2,
      REG_CLIP_Y_MAX = 3'd3,
      REG_ROW_STRIDE = 3'd4,
      REG_INK_COLOR  = 3'd5
   } reg_index_type;

   localparam logic [CLIP_BITS-1:0] CLIP_X_MAX_RESET = CLIP_BITS'(1023);
   localparam logic [CLIP_BITS-1:0] CLIP_Y_MAX_RESET = CLIP_BITS'(767);
   localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET = STRIDE_BITS'(1024);

endpackage

[hw/rtl/clipped_line_rasterizer.sv]
// Top level of the clipped line rasterizer: line engine, window test and offset stage.
//
// Bresenham line engine with clipping. A start word (tuser low) loads both endpoints and
// yields the first pixel; each step word (tuser high) yields the next pixel, and the final
// pixel of a line comes out with rsp_tlast set. Step words while no line is open are taken
// and yield nothing; a start word drops any open line. While rsp_tready does not stall it,
// the block takes one word per clock and sustains one pixel per clock. A pixel passes the
// line engine register (decision update, endpoint test), then the output register (window
// test, y*stride+x multiply-add). Ready follows rsp_tready only when both stages are full.
// The user must write configuration through the csr port while idle; the block does not check it.
module clipped_line_rasterizer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // x_start, y_start, x_end, y_end, zero fill
   input  logic [clr_pkg::IN_DATA_BITS-1:0]       req_tdata,
   // kind: 0 start, 1 step
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pixel_x, pixel_y, inside_window, word_offset, pixel_color, zero fill
   output logic [clr_pkg::OUT_DATA_BITS-1:0]      rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic [clr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [clr_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import clr_pkg::*;

   // configuration
   logic [CLIP_BITS-1:0]   clip_x_min_ff, clip_x_max_ff, clip_y_min_ff, clip_y_max_ff;
   logic [STRIDE_BITS-1:0] row_stride_ff;
   logic [COLOR_BITS-1:0]  ink_color_ff;

   // line engine; cur_x/cur_y double as the first pipeline stage payload
   logic       line_active_ff, line_active_in;
   coord_type  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   coord_type  major_end_ff, major_end_in;
   dec_type    decision_ff, decision_in;
   dec_type    inc_straight_ff, inc_straight_in;
   dec_type    inc_diagonal_ff, inc_diagonal_in;
   octant_type octant_ff, octant_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_last_ff, s1_last_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   coord_type                out_x_ff, out_y_ff;
   logic                     out_inside_ff, out_inside_in;
   off_type                  out_offset_ff, out_offset_in;
   logic [COLOR_BITS-1:0]    out_color_ff;
   logic                     out_last_ff;

   logic      s2_ready, s1_ready, accept, is_start, produce, s2_load;
   coord_type xs, ys, xe, ye;
   off_type   y_ext, x_ext, prod;
   cmp_type   cx, cy;

   assign xs = coord_type'(req_tdata[COORD_BITS-1:0]);
   assign ys = coord_type'(req_tdata[2*COORD_BITS-1:COORD_BITS]);
   assign xe = coord_type'(req_tdata[3*COORD_BITS-1:2*COORD_BITS]);
   assign ye = coord_type'(req_tdata[4*COORD_BITS-1:3*COORD_BITS]);

   // handshake and stage control
   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;
   assign is_start   = (kind_type'(req_tuser) == KIND_START);
   assign produce    = accept && (is_start || line_active_ff);
   assign s2_load    = s1_valid_ff && s2_ready;
   assign s1_valid_in  = produce || (s1_valid_ff && !s2_ready);
   assign rsp_valid_in = s2_load || (rsp_valid_ff && !rsp_tready);

   // line engine next state
   always_comb begin
      coord_type ax, ay, bx, by;
      diff_type  dx, dy;
      dec_type   dxe, dye;
      logic      diag;
      coord_type nx, ny;
      ax = xs;
      ay = ys;
      bx = xe;
      by = ye;
      if (xs > xe) begin
         ax = xe;
         ay = ye;
         bx = xs;
         by = ys;
      end
      dx  = diff_type'(bx) - diff_type'(ax);
      dy  = diff_type'(by) - diff_type'(ay);
      dxe = dec_type'(dx);
      dye = dec_type'(dy);
      diag = (decision_ff > dec_type'(0));
      nx = cur_x_ff;
      ny = cur_y_ff;

      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      major_end_in    = major_end_ff;
      decision_in     = decision_ff;
      inc_straight_in = inc_straight_ff;
      inc_diagonal_in = inc_diagonal_ff;
      octant_in       = octant_ff;
      s1_last_in      = s1_last_ff;

      if (is_start) begin
         cur_x_in = ax;
         cur_y_in = ay;
         if (by > ay) begin
            if (dx > dy) begin
               octant_in       = OCT_X_UP;
               major_end_in    = bx;
               decision_in     = (dye <<< 1) - dxe;
               inc_straight_in = dye <<< 1;
               inc_diagonal_in = (dye - dxe) <<< 1;
            end else begin
               octant_in       = OCT_Y_UP;
               major_end_in    = by;
               decision_in     = (dxe <<< 1) - dye;
               inc_straight_in = dxe <<< 1;
               inc_diagonal_in = (dxe - dye) <<< 1;
            end
         end else begin
            if (dx > -dy) begin
               octant_in       = OCT_X_DOWN;
               major_end_in    = bx;
               decision_in     = -(dye <<< 1) - dxe;
               inc_straight_in = -(dye <<< 1);
               inc_diagonal_in = (-dye - dxe) <<< 1;
            end else begin
               octant_in       = OCT_Y_DOWN;
               major_end_in    = by;
               decision_in     = (dxe <<< 1) + dye;
               inc_straight_in = dxe <<< 1;
               inc_diagonal_in = (dxe + dye) <<< 1;
            end
         end
         // every octant with distinct endpoints has at least one step left
         s1_last_in = (xs == xe) && (ys == ye);
      end else begin
         decision_in = decision_ff + (diag ? inc_diagonal_ff : inc_straight_ff);
         case (octant_ff)
            OCT_X_UP: begin
               nx = cur_x_ff + coord_type'(1);
               ny = cur_y_ff + coord_type'(diag);
               s1_last_in = !(nx < major_end_ff);
            end
            OCT_X_DOWN: begin
               nx = cur_x_ff + coord_type'(1);
               ny = cur_y_ff - coord_type'(diag);
               s1_last_in = !(nx < major_end_ff);
            end
            OCT_Y_UP: begin
               nx = cur_x_ff + coord_type'(diag);
               ny = cur_y_ff + coord_type'(1);
               s1_last_in = !(ny < major_end_ff);
            end
            default: begin
               nx = cur_x_ff + coord_type'(diag);
               ny = cur_y_ff - coord_type'(1);
               s1_last_in = !(ny > major_end_ff);
            end
         endcase
         cur_x_in = nx;
         cur_y_in = ny;
      end
      line_active_in = !s1_last_in;
   end

   // window test and frame offset
   assign cx = cmp_type'(cur_x_ff);
   assign cy = cmp_type'(cur_y_ff);
   assign out_inside_in = (cx >= cmp_type'($signed({1'b0, clip_x_min_ff}))) &&
                          (cx <= cmp_type'($signed({1'b0, clip_x_max_ff}))) &&
                          (cy >= cmp_type'($signed({1'b0, clip_y_min_ff}))) &&
                          (cy <= cmp_type'($signed({1'b0, clip_y_max_ff})));
   assign y_ext = off_type'(cur_y_ff);
   assign x_ext = off_type'(cur_x_ff);
   assign prod  = OFF_BITS'(y_ext * off_type'(row_stride_ff));
   assign out_offset_in = out_inside_in ? (prod + x_ext) : '0;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         clip_x_min_ff  <= '0;
         clip_x_max_ff  <= CLIP_X_MAX_RESET;
         clip_y_min_ff  <= '0;
         clip_y_max_ff  <= CLIP_Y_MAX_RESET;
         row_stride_ff  <= ROW_STRIDE_RESET;
         ink_color_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (produce) begin
            line_active_ff <= line_active_in;
         end
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_CLIP_X_MIN: clip_x_min_ff <= csr_wdata[CLIP_BITS-1:0];
               REG_CLIP_X_MAX: clip_x_max_ff <= csr_wdata[CLIP_BITS-1:0];
               REG_CLIP_Y_MIN: clip_y_min_ff <= csr_wdata[CLIP_BITS-1:0];
               REG_CLIP_Y_MAX: clip_y_max_ff <= csr_wdata[CLIP_BITS-1:0];
               REG_ROW_STRIDE: row_stride_ff <= csr_wdata[STRIDE_BITS-1:0];
               REG_INK_COLOR:  ink_color_ff  <= csr_wdata[COLOR_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (produce) begin
         cur_x_ff        <= cur_x_in;
         cur_y_ff        <= cur_y_in;
         major_end_ff    <= major_end_in;
         decision_ff     <= decision_in;
         inc_straight_ff <= inc_straight_in;
         inc_diagonal_ff <= inc_diagonal_in;
         octant_ff       <= octant_in;
         s1_last_ff      <= s1_last_in;
      end
      if (s2_load) begin
         out_x_ff      <= cur_x_ff;
         out_y_ff      <= cur_y_ff;
         out_inside_ff <= out_inside_in;
         out_offset_ff <= out_offset_in;
         out_color_ff  <= ink_color_ff;
         out_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = OUT_DATA_BITS'({out_color_ff, out_offset_ff, out_inside_ff,
                                       out_y_ff, out_x_ff});

`ifndef SYNTHESIS
   // a pixel outside the window never carries an offset
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_inside_ff) |-> (out_offset_ff == '0))
      else $error("offset nonzero for a clipped pixel");

   // a step word with no open line makes no pixel
   assert property (@(posedge clock) disable iff (reset)
      (accept && !is_start && !line_active_ff) |=> !s1_valid_ff)
      else $error("pixel produced with no open line");

   // the final pixel closes the line
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff) |-> !line_active_ff)
      else $error("line still open after its last pixel");

   // a single point line is one pixel, marked last
   assert property (@(posedge clock) disable iff (reset)
      (accept && is_start && (xs == xe) && (ys == ye)) |=> (s1_valid_ff && s1_last_ff))
      else $error("single point line not marked last");
`endif

endmodule
